@@ sv/osvl_pkg.sv @@
`timescale 1ns / 1ps

package osvl_pkg;

    localparam int LINE_WIDTH = 256;
    localparam int IDX_W      = $clog2(LINE_WIDTH);
    localparam int SAMP_W     = 16;
    localparam int LINE_W     = 3 * SAMP_W;
    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 24;
    localparam int DIST_W     = 24;
    localparam int ROOT_ITERS = 30;
    localparam int DIV_ITERS  = 9;
    localparam int ITER_W     = 5;

    // request field positions inside s_tdata
    localparam int F_POS   = 0;
    localparam int F_XH    = 8;
    localparam int F_XB    = 24;
    localparam int F_XA    = 40;
    localparam int F_YH    = 56;
    localparam int F_YB    = 72;
    localparam int F_YA    = 88;
    localparam int F_STEP  = 104;

    // configuration register indexes
    localparam logic [2:0] REG_CENTER = 3'd0;
    localparam logic [2:0] REG_COS    = 3'd1;
    localparam logic [2:0] REG_SIN    = 3'd2;
    localparam logic [2:0] REG_TAN    = 3'd3;
    localparam logic [2:0] REG_COT    = 3'd4;
    localparam logic [2:0] REG_SEC    = 3'd5;
    localparam logic [2:0] REG_CSC    = 3'd6;

    typedef struct packed {
        logic [7:0]  center;
        logic [14:0] cosv;
        logic [14:0] sinv;
        logic [15:0] tanv;
        logic [15:0] cotv;
        logic [15:0] secv;
        logic [15:0] cscv;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ,
        ST_P_ADDR, ST_P_MUL, ST_P_SUM, ST_P_PROD, ST_P_DIST, ST_P_CMP,
        ST_H_CHK, ST_H_WR,
        ST_S_RD, ST_S_SEL, ST_S_HI, ST_S_LO, ST_S_K, ST_S_GRAD, ST_S_MUL,
        ST_S_SUM, ST_S_ROOT, ST_S_NUMER, ST_S_DIV, ST_S_WR
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_LOAD_LAST, OP_READ, OP_RESULT,
        OP_P_ADDR, OP_P_MUL, OP_P_SUM, OP_P_PROD, OP_P_DIST, OP_P_CMP,
        OP_H_CHK, OP_H_WR,
        OP_S_RD, OP_S_SEL, OP_S_HI, OP_S_LO, OP_S_K, OP_S_GRAD, OP_S_MUL,
        OP_S_SUM, OP_S_ROOT, OP_S_NUMER, OP_S_DIV, OP_S_WR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic             xph;
        logic             first;
    } cmd_t;

    typedef struct packed {
        logic cov_here;
        logic out_busy;
    } sts_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic [IDX_W-1:0]         src;
        logic                     vx;
    } near_t;

    typedef struct packed {
        logic       covered;
        logic [7:0] depth;
        logic [7:0] shade;
        logic [7:0] pix;
    } res_t;

endpackage

@@ sv/osvl_ctrl.sv @@
`timescale 1ns / 1ps

module osvl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            s_tlast,
    input  logic            s_tuser,
    input  osvl_pkg::sts_t  sts,
    output osvl_pkg::cmd_t  cmd
);
    import osvl_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W:0]    cnt_reg, cnt_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        iter_next  = iter_reg;
        s_tready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg[IDX_W-1:0];
        cmd.xph    = cnt_reg[IDX_W];
        cmd.first  = (iter_reg == ITER_W'(DIV_ITERS - 1));
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = !sts.out_busy;
                if (s_tvalid && !sts.out_busy)
                begin
                    if (s_tuser)
                    begin
                        cmd.op     = OP_READ;
                        state_next = ST_READ;
                    end
                    else if (s_tlast)
                    begin
                        cmd.op     = OP_LOAD_LAST;
                        cnt_next   = '0;
                        state_next = ST_P_ADDR;
                    end
                    else
                        cmd.op = OP_LOAD;
                end
            end
            ST_READ:
            begin
                cmd.op     = OP_RESULT;
                state_next = ST_IDLE;
            end
            ST_P_ADDR:
            begin
                cmd.op     = OP_P_ADDR;
                state_next = ST_P_MUL;
            end
            ST_P_MUL:
            begin
                cmd.op     = OP_P_MUL;
                state_next = ST_P_SUM;
            end
            ST_P_SUM:
            begin
                cmd.op     = OP_P_SUM;
                state_next = ST_P_PROD;
            end
            ST_P_PROD:
            begin
                cmd.op     = OP_P_PROD;
                state_next = ST_P_DIST;
            end
            ST_P_DIST:
            begin
                cmd.op     = OP_P_DIST;
                state_next = ST_P_CMP;
            end
            ST_P_CMP:
            begin
                cmd.op = OP_P_CMP;
                if (cnt_reg == (IDX_W+1)'(2 * LINE_WIDTH - 1))
                begin
                    cnt_next   = (IDX_W+1)'(1);
                    state_next = ST_H_CHK;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_P_ADDR;
                end
            end
            ST_H_CHK:
            begin
                cmd.op     = OP_H_CHK;
                state_next = ST_H_WR;
            end
            ST_H_WR:
            begin
                cmd.op = OP_H_WR;
                if (cnt_reg == (IDX_W+1)'(LINE_WIDTH - 2))
                begin
                    cnt_next   = '0;
                    state_next = ST_S_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_H_CHK;
                end
            end
            ST_S_RD:
            begin
                cmd.op     = OP_S_RD;
                state_next = sts.cov_here ? ST_S_SEL : ST_S_WR;
            end
            ST_S_SEL:
            begin
                cmd.op     = OP_S_SEL;
                state_next = ST_S_HI;
            end
            ST_S_HI:
            begin
                cmd.op     = OP_S_HI;
                state_next = ST_S_LO;
            end
            ST_S_LO:
            begin
                cmd.op     = OP_S_LO;
                state_next = ST_S_K;
            end
            ST_S_K:
            begin
                cmd.op     = OP_S_K;
                state_next = ST_S_GRAD;
            end
            ST_S_GRAD:
            begin
                cmd.op     = OP_S_GRAD;
                state_next = ST_S_MUL;
            end
            ST_S_MUL:
            begin
                cmd.op     = OP_S_MUL;
                state_next = ST_S_SUM;
            end
            ST_S_SUM:
            begin
                cmd.op     = OP_S_SUM;
                iter_next  = ITER_W'(ROOT_ITERS - 1);
                state_next = ST_S_ROOT;
            end
            ST_S_ROOT:
            begin
                cmd.op    = OP_S_ROOT;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                    state_next = ST_S_NUMER;
            end
            ST_S_NUMER:
            begin
                cmd.op     = OP_S_NUMER;
                iter_next  = ITER_W'(DIV_ITERS - 1);
                state_next = ST_S_DIV;
            end
            ST_S_DIV:
            begin
                cmd.op    = OP_S_DIV;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                    state_next = ST_S_WR;
            end
            ST_S_WR:
            begin
                cmd.op = OP_S_WR;
                if (cnt_reg == (IDX_W+1)'(LINE_WIDTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_S_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

@@ sv/osvl_datapath.sv @@
`timescale 1ns / 1ps

module osvl_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  osvl_pkg::cmd_t                    cmd,
    input  osvl_pkg::cfg_t                    cfg,
    input  logic [osvl_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              cov_here,
    output osvl_pkg::res_t                    res
);
    import osvl_pkg::*;

    logic [LINE_W-1:0] x_mem [LINE_WIDTH];
    logic [LINE_W-1:0] y_mem [LINE_WIDTH];
    near_t             near_mem [LINE_WIDTH];
    logic [15:0]       pout_mem [LINE_WIDTH];

    logic [LINE_WIDTH-1:0] cov_reg;
    logic [1:0]            step_reg;
    logic                  computed_reg;

    logic [IDX_W-1:0]  samp_addr, near_addr, pos;
    logic [LINE_W-1:0] x_q, y_q, line_q, x_wr, y_wr;
    near_t             near_q, near_wr;

    // projection pipeline
    logic [22:0]                mo_reg;
    logic [30:0]                sb_reg;
    logic [31:0]                sr_reg, su_reg;
    logic signed [11:0]         steps_reg;
    logic signed [33:0]         e_reg;
    logic signed [49:0]         f_reg;
    logic [IDX_W-1:0]           pidx_reg;
    logic                       pin_reg;
    logic signed [DIST_W-1:0]   dq_reg;
    logic                       hole_reg;

    // shading
    logic [IDX_W-1:0]         k_reg, lo_reg, hi_reg;
    logic                     ends_reg, vx_reg;
    logic signed [DIST_W-1:0] nd_reg;
    logic [15:0]              hh_reg, lh_reg;
    logic signed [21:0]       gx_reg, gy_reg, gz_reg;
    logic signed [37:0]       n1_reg, n2_reg;
    logic [39:0]              sq1_reg, sq2_reg, sq3_reg;
    logic signed [38:0]       num_reg;
    logic [59:0]              rad_reg;
    logic [33:0]              rem_reg;
    logic [29:0]              root_reg;
    logic [56:0]              drem_reg;
    logic [51:0]              dsh_reg;
    logic [7:0]               quo_reg;
    logic                     sat_reg, npos_reg;
    logic [15:0]              pout_q;
    logic                     covq_reg;
    logic [7:0]               pos_reg;

    logic [IDX_W-1:0] off;
    logic [15:0]      samp;
    logic [14:0]      pa, pb;
    logic [15:0]      pr, pu;
    logic signed [32:0] tq;
    logic [32:0]        tmag;
    logic [10:0]        tsh;
    logic signed [11:0] steps_c;
    logic signed [33:0] e_c;
    logic signed [12:0] idx13;
    logic signed [51:0] d_c, dr_c;
    logic signed [DIST_W-1:0] dq_c;
    logic               upd;
    logic [1:0]         zval;
    logic signed [16:0] diff, dz;
    logic signed [21:0] gd, gc, gzc, diff22, dz22, z22;
    logic               inner_y;
    logic [20:0]        gxm, gym, gzm;
    logic [33:0]        remsh, trial;
    logic signed [57:0] n58, numer;
    logic               ge;
    logic signed [25:0] tdep;
    logic [7:0]         dep, shd;
    logic               hole_c;
    logic [IDX_W-1:0]   kk, klo, khi;
    logic               kend;

    assign pos  = s_tdata[F_POS +: IDX_W];
    assign x_wr = {s_tdata[F_XA +: SAMP_W], s_tdata[F_XB +: SAMP_W], s_tdata[F_XH +: SAMP_W]};
    assign y_wr = {s_tdata[F_YA +: SAMP_W], s_tdata[F_YB +: SAMP_W], s_tdata[F_YH +: SAMP_W]};
    assign cov_here = cov_reg[cmd.idx];
    assign near_wr  = '{distance: dq_reg, src: cmd.idx, vx: cmd.xph};

    always_comb
    begin
        case (cmd.op)
            OP_S_HI: samp_addr = hi_reg;
            OP_S_LO: samp_addr = lo_reg;
            OP_S_K:  samp_addr = k_reg;
            default: samp_addr = cmd.idx;
        endcase
        case (cmd.op)
            OP_P_DIST: near_addr = pidx_reg;
            OP_H_CHK:  near_addr = cmd.idx - 1'b1;
            default:   near_addr = cmd.idx;
        endcase
    end

    // projection arithmetic
    always_comb
    begin
        off    = ~cmd.idx;
        samp   = cmd.xph ? x_q[15:0] : y_q[15:0];
        pa     = cmd.xph ? cfg.sinv : cfg.cosv;
        pb     = cmd.xph ? cfg.cosv : cfg.sinv;
        pr     = cmd.xph ? cfg.cscv : cfg.secv;
        pu     = cmd.xph ? cfg.cotv : cfg.tanv;
        tq     = $signed({2'b0, mo_reg, 8'b0}) - $signed({2'b0, sb_reg});
        tmag   = tq[32] ? 33'(-tq) : 33'(tq);
        tsh    = tmag[32:22];
        steps_c = tq[32] ? -$signed({1'b0, tsh}) : $signed({1'b0, tsh});
        e_c    = $signed({6'b0, off, 20'b0}) - $signed({2'b0, su_reg});
        idx13  = cmd.xph ? $signed({5'b0, cfg.center}) + 13'(steps_reg)
                         : $signed({5'b0, cfg.center}) - 13'(steps_reg);
        d_c    = $signed({6'b0, sr_reg, 14'b0}) - 52'(f_reg);
        dr_c   = d_c + 52'sd33554432;
        if ((dr_c >>> 26) > 52'sd8388607)
            dq_c = 24'sh7FFFFF;
        else if ((dr_c >>> 26) < -52'sd8388608)
            dq_c = 24'sh800000;
        else
            dq_c = 24'(dr_c >>> 26);
        upd    = pin_reg && (!cov_reg[pidx_reg] || (near_q.distance > dq_reg));
        hole_c = !cov_reg[cmd.idx] && cov_reg[cmd.idx - 1'b1] && cov_reg[cmd.idx + 1'b1];
    end

    // shading arithmetic
    always_comb
    begin
        kk   = near_q.src;
        kend = (kk == '0) || (kk == IDX_W'(LINE_WIDTH - 1));
        if (kk == '0)
        begin
            klo = '0;
            khi = IDX_W'(1);
        end
        else if (kk == IDX_W'(LINE_WIDTH - 1))
        begin
            klo = IDX_W'(LINE_WIDTH - 2);
            khi = IDX_W'(LINE_WIDTH - 1);
        end
        else
        begin
            klo = kk - 1'b1;
            khi = kk + 1'b1;
        end
        line_q  = vx_reg ? x_q : y_q;
        zval    = (step_reg == 2'd0) ? 2'd1 : step_reg;
        diff    = $signed({1'b0, hh_reg}) - $signed({1'b0, lh_reg});
        dz      = $signed({1'b0, line_q[31:16]}) - $signed({1'b0, line_q[47:32]});
        diff22  = 22'(diff);
        dz22    = 22'(dz);
        z22     = $signed(22'(zval));
        inner_y = !vx_reg && !ends_reg;
        gd      = (diff22 * z22) <<< 1;
        gc      = inner_y ? $signed({10'b0, zval, 10'b0}) : $signed({11'b0, zval, 9'b0});
        gzc     = inner_y ? (dz22 <<< 2) : (dz22 <<< 1);
        gxm     = gx_reg[21] ? 21'(-gx_reg) : 21'(gx_reg);
        gym     = gy_reg[21] ? 21'(-gy_reg) : 21'(gy_reg);
        gzm     = gz_reg[21] ? 21'(-gz_reg) : 21'(gz_reg);
        remsh   = {rem_reg[31:0], rad_reg[59:58]};
        trial   = {2'b0, root_reg, 2'b01};
        n58     = 58'(num_reg);
        numer   = (((n58 <<< 8) - n58) <<< 10) + $signed({15'b0, root_reg, 13'b0});
        ge      = {5'b0, dsh_reg} <= drem_reg;
        tdep    = 26'sd65280 - 26'(nd_reg);
        if (nd_reg >= 24'sd65536 || tdep <= 26'sd0)
            dep = 8'd0;
        else if (tdep[25:8] > 18'd255)
            dep = 8'd255;
        else
            dep = tdep[15:8];
        if (!npos_reg || root_reg == '0)
            shd = 8'd0;
        else if (sat_reg)
            shd = 8'd255;
        else
            shd = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cov_reg      <= '0;
            step_reg     <= 2'd1;
            computed_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD_LAST:
                begin
                    cov_reg      <= '0;
                    step_reg     <= s_tdata[F_STEP +: 2];
                    computed_reg <= 1'b1;
                end
                OP_P_CMP:
                    if (upd)
                        cov_reg[pidx_reg] <= 1'b1;
                OP_H_WR:
                    if (hole_reg)
                        cov_reg[cmd.idx] <= 1'b1;
                default:
                    ;
            endcase
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD || cmd.op == OP_LOAD_LAST)
        begin
            x_mem[pos] <= x_wr;
            y_mem[pos] <= y_wr;
        end
        x_q <= x_mem[samp_addr];
        y_q <= y_mem[samp_addr];

        if (cmd.op == OP_P_CMP && upd)
            near_mem[pidx_reg] <= near_wr;
        else if (cmd.op == OP_H_WR && hole_reg)
            near_mem[cmd.idx] <= near_q;
        near_q <= near_mem[near_addr];

        if (cmd.op == OP_S_WR)
            pout_mem[cmd.idx] <= cov_reg[cmd.idx] ? {shd, dep} : 16'd0;
        if (cmd.op == OP_READ)
            pout_q <= pout_mem[pos];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_READ:
            begin
                pos_reg  <= pos;
                covq_reg <= cov_reg[pos];
            end
            OP_P_MUL:
            begin
                mo_reg <= 23'(off) * 23'(pa);
                sb_reg <= 31'(samp) * 31'(pb);
                sr_reg <= 32'(samp) * 32'(pr);
                su_reg <= 32'(samp) * 32'(pu);
            end
            OP_P_SUM:
            begin
                steps_reg <= steps_c;
                e_reg     <= e_c;
            end
            OP_P_PROD:
            begin
                f_reg    <= 50'(e_reg) * $signed({35'b0, pb});
                pidx_reg <= idx13[IDX_W-1:0];
                pin_reg  <= (idx13[12:IDX_W] == '0);
            end
            OP_P_DIST:
                dq_reg <= dq_c;
            OP_H_CHK:
                hole_reg <= hole_c;
            OP_S_SEL:
            begin
                k_reg    <= kk;
                lo_reg   <= klo;
                hi_reg   <= khi;
                ends_reg <= kend;
                vx_reg   <= near_q.vx;
                nd_reg   <= near_q.distance;
            end
            OP_S_LO:
                hh_reg <= line_q[15:0];
            OP_S_K:
                lh_reg <= line_q[15:0];
            OP_S_GRAD:
            begin
                gx_reg <= vx_reg ? gc : gd;
                gy_reg <= vx_reg ? gd : gc;
                gz_reg <= gzc;
            end
            OP_S_MUL:
            begin
                n1_reg  <= 38'(gx_reg) * $signed({23'b0, cfg.sinv});
                n2_reg  <= 38'(gy_reg) * $signed({23'b0, cfg.cosv});
                sq1_reg <= 40'(gxm) * 40'(gxm);
                sq2_reg <= 40'(gym) * 40'(gym);
                sq3_reg <= 40'(gzm) * 40'(gzm);
            end
            OP_S_SUM:
            begin
                num_reg  <= 39'(n1_reg) + 39'(n2_reg);
                rad_reg  <= {sq1_reg + sq2_reg + sq3_reg, 20'b0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_S_ROOT:
            begin
                rad_reg <= rad_reg << 2;
                if (remsh >= trial)
                begin
                    rem_reg  <= remsh - trial;
                    root_reg <= {root_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= remsh;
                    root_reg <= {root_reg[28:0], 1'b0};
                end
            end
            OP_S_NUMER:
            begin
                npos_reg <= (numer > 58'sd0);
                drem_reg <= numer[56:0];
                dsh_reg  <= {root_reg, 22'b0};
                quo_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            OP_S_DIV:
            begin
                dsh_reg <= dsh_reg >> 1;
                if (cmd.first)
                    sat_reg <= ge;
                else
                begin
                    quo_reg <= {quo_reg[6:0], ge};
                    if (ge)
                        drem_reg <= drem_reg - {5'b0, dsh_reg};
                end
            end
            default:
                ;
        endcase
    end

    always_comb
    begin
        res.pix     = pos_reg;
        res.shade   = computed_reg ? pout_q[15:8] : 8'd0;
        res.depth   = computed_reg ? pout_q[7:0] : 8'd0;
        res.covered = covq_reg;
    end

endmodule

@@ sv/oblique_surface_view_line.sv @@
`timescale 1ns / 1ps
// Load request: accepted when idle and no result waits; a line_end load then runs the
// line computation: projection of all 512 samples, hole fill of the inner positions,
// then shading of each pixel, with the iterative root and divide for covered pixels.
// Read request: registered in pout_q, then in the output register; one at a time.
// Reset clears control state and loads the register defaults; no memory is swept, and
// pixels read as zero until the first line has been computed.

module oblique_surface_view_line (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // position, x_here, x_before, x_after, y_here, y_before, y_after, slice_step
    input  logic [osvl_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_index, shade, depth
    output logic [osvl_pkg::M_DATA_W-1:0]  m_tdata,
    // covered
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);
    import osvl_pkg::*;

    cfg_t cfg_reg;
    res_t out_reg;
    res_t res;
    logic out_valid_reg;
    cmd_t cmd;
    sts_t sts;
    logic cov_here;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center <= 8'd127;
            cfg_reg.cosv   <= 15'd11585;
            cfg_reg.sinv   <= 15'd11585;
            cfg_reg.tanv   <= 16'd4096;
            cfg_reg.cotv   <= 16'd4096;
            cfg_reg.secv   <= 16'd5793;
            cfg_reg.cscv   <= 16'd5793;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER: cfg_reg.center <= cfg_data[7:0];
                REG_COS:    cfg_reg.cosv   <= cfg_data[14:0];
                REG_SIN:    cfg_reg.sinv   <= cfg_data[14:0];
                REG_TAN:    cfg_reg.tanv   <= cfg_data;
                REG_COT:    cfg_reg.cotv   <= cfg_data;
                REG_SEC:    cfg_reg.secv   <= cfg_data;
                REG_CSC:    cfg_reg.cscv   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_RESULT)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RESULT)
            out_reg <= res;
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {out_reg.depth, out_reg.shade, out_reg.pix};
    assign m_tuser      = out_reg.covered;
    assign sts.out_busy = out_valid_reg;
    assign sts.cov_here = cov_here;

    osvl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    osvl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .cov_here (cov_here),
        .res      (res)
    );

endmodule
